// ===== hdl/es2d_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// es2d_pkg
// Shared types, microcode and calendar helpers for the epoch seconds to date
// conversion unit.
// ----------------------------------------------------------------------------
package es2d_pkg;

   // Microcode operation codes
   localparam logic [1:0] OP_WAIT  = 2'd0;
   localparam logic [1:0] OP_DIV   = 2'd1;
   localparam logic [1:0] OP_YEAR  = 2'd2;
   localparam logic [1:0] OP_MONTH = 2'd3;

   // Destination codes for the remainder of a division step
   localparam logic [1:0] DEST_NONE = 2'd0;
   localparam logic [1:0] DEST_SEC  = 2'd1;
   localparam logic [1:0] DEST_MIN  = 2'd2;
   localparam logic [1:0] DEST_HOUR = 2'd3;

   // Step addresses of the program
   localparam int           PC_W       = 3;
   localparam logic [2:0]   PC_WAIT    = 3'd0;
   localparam logic [2:0]   PC_DIV_SEC = 3'd1;
   localparam logic [2:0]   PC_DIV_MIN = 3'd2;
   localparam logic [2:0]   PC_DIV_HR  = 3'd3;
   localparam logic [2:0]   PC_YEAR    = 3'd4;
   localparam logic [2:0]   PC_MONTH   = 3'd5;

   // Each division has a reciprocal product step, then a remainder step
   localparam int         ITER_W    = 1;
   localparam logic [0:0] ITER_LAST = 1'b1;

   // Reciprocals of the divisors: quotient is product >> 37 for 60, >> 36 for 24
   localparam logic [31:0] RECIP_60 = 32'h8888_8889;
   localparam logic [31:0] RECIP_24 = 32'hAAAA_AAAB;

   localparam logic [5:0]  DIV_60     = 6'd60;
   localparam logic [5:0]  DIV_24     = 6'd24;
   localparam logic [11:0] BASE_YEAR  = 12'd1970;
   localparam logic [1:0]  BASE_MOD4  = 2'd2;
   localparam logic [6:0]  BASE_MOD100 = 7'd70;
   localparam logic [8:0]  BASE_MOD400 = 9'd370;
   localparam logic [6:0]  LAST_MOD100 = 7'd99;
   localparam logic [8:0]  LAST_MOD400 = 9'd399;
   localparam logic [8:0]  DAYS_LEAP   = 9'd366;
   localparam logic [8:0]  DAYS_COMMON = 9'd365;
   localparam logic [3:0]  MONTH_JAN   = 4'd1;
   localparam logic [3:0]  MONTH_FEB   = 4'd2;
   localparam logic [3:0]  MONTH_DEC   = 4'd12;

   // One control word per program step
   typedef struct packed {
      logic [1:0]      op;
      logic [5:0]      divisor;
      logic [1:0]      dest;
      logic [PC_W-1:0] target;
   } ctrl_word_type;

   // Datapath conditions fed back to the sequencer
   typedef struct packed {
      logic accept;
      logic year_fit;
      logic month_fit;
   } status_type;

   // Sequencer outputs to the datapath
   typedef struct packed {
      ctrl_word_type word;
      logic          div_last;
   } seq_ctrl_type;

   // Program store
   function automatic ctrl_word_type ucode_rom(input logic [PC_W-1:0] pc);
      ctrl_word_type w;
      w = '{op: OP_WAIT, divisor: DIV_60, dest: DEST_NONE, target: PC_DIV_SEC};
      unique case (pc)
         PC_WAIT:    w = '{op: OP_WAIT,  divisor: DIV_60, dest: DEST_NONE,
                           target: PC_DIV_SEC};
         PC_DIV_SEC: w = '{op: OP_DIV,   divisor: DIV_60, dest: DEST_SEC,
                           target: PC_DIV_MIN};
         PC_DIV_MIN: w = '{op: OP_DIV,   divisor: DIV_60, dest: DEST_MIN,
                           target: PC_DIV_HR};
         PC_DIV_HR:  w = '{op: OP_DIV,   divisor: DIV_24, dest: DEST_HOUR,
                           target: PC_YEAR};
         PC_YEAR:    w = '{op: OP_YEAR,  divisor: DIV_60, dest: DEST_NONE,
                           target: PC_MONTH};
         PC_MONTH:   w = '{op: OP_MONTH, divisor: DIV_60, dest: DEST_NONE,
                           target: PC_WAIT};
         default:    w = '{op: OP_WAIT,  divisor: DIV_60, dest: DEST_NONE,
                           target: PC_WAIT};
      endcase
      return w;
   endfunction

   // Common-year month lengths
   function automatic logic [4:0] month_len(input logic [3:0] m);
      logic [4:0] n;
      unique case (m)
         4'd2:                      n = 5'd28;
         4'd4, 4'd6, 4'd9, 4'd11:   n = 5'd30;
         default:                   n = 5'd31;
      endcase
      return n;
   endfunction

endpackage

// ===== hdl/es2d_sequencer.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// es2d_sequencer
// Step counter, program store and iteration counter; jumps to the target of
// the current control word when its exit condition holds.
// ----------------------------------------------------------------------------
module es2d_sequencer
   import es2d_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  status_type   status,
   output seq_ctrl_type ctrl
);

   logic [PC_W-1:0]   pc_ff, pc_in;
   logic [ITER_W-1:0] iter_ff, iter_in;
   ctrl_word_type     word;
   logic              div_last;
   logic              take_jump;

   // Fetch the control word
   assign word     = ucode_rom(pc_ff);
   assign div_last = (word.op == OP_DIV) && (iter_ff == ITER_LAST);

   // Evaluate the exit condition of the step
   always_comb begin
      unique case (word.op)
         OP_WAIT:  take_jump = status.accept;
         OP_DIV:   take_jump = div_last;
         OP_YEAR:  take_jump = status.year_fit;
         OP_MONTH: take_jump = status.month_fit;
         default:  take_jump = 1'b0;
      endcase
   end

   // Advance the step counter and the division iteration count
   always_comb begin
      pc_in   = take_jump ? word.target : pc_ff;
      iter_in = (word.op == OP_DIV) ? iter_ff + 1'b1 : '0;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pc_ff   <= PC_WAIT;
         iter_ff <= '0;
      end else begin
         pc_ff   <= pc_in;
         iter_ff <= iter_in;
      end
   end

   assign ctrl.word     = word;
   assign ctrl.div_last = div_last;

endmodule

// ===== hdl/epoch_seconds_to_date_fields_unit.sv =====
`timescale 1ns / 1ps
// Steps from acceptance to rsp_valid: two each for /60, /60 and /24, then the year
// step, which removes whole years, and the month step, which removes whole months.
// A result still waiting in the output register stalls the next at its month step.
// One request is worked on at a time; a new request is taken while a finished
// result waits in the output register.
// Reset (synchronous, active high) returns to the wait step, drops any result.
// ----------------------------------------------------------------------------
// epoch_seconds_to_date_fields_unit
// Converts unsigned Unix seconds into Gregorian date and time of day under a
// short microcode program driving a shared divider and calendar datapath.
// ----------------------------------------------------------------------------
module epoch_seconds_to_date_fields_unit
   import es2d_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [31:0] req_epoch_seconds,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [5:0]  rsp_second_of_minute,
   output logic [5:0]  rsp_minute_of_hour,
   output logic [4:0]  rsp_hour_of_day,
   output logic [4:0]  rsp_day_of_month,
   output logic [3:0]  rsp_month_of_year,
   output logic [11:0] rsp_year
);

   seq_ctrl_type ctrl;
   status_type   status;

   logic [31:0] q_ff, q_in;
   logic [31:0] quo_ff, quo_in;
   logic [5:0]  sec_ff, sec_in;
   logic [5:0]  min_ff, min_in;
   logic [4:0]  hour_ff, hour_in;
   logic [15:0] day_ff, day_in;
   logic [11:0] year_ff, year_in;
   logic [3:0]  month_ff, month_in;
   logic [1:0]  mod4_ff, mod4_in;
   logic [6:0]  mod100_ff, mod100_in;
   logic [8:0]  mod400_ff, mod400_in;

   logic        rsp_valid_ff, rsp_valid_in;
   logic [5:0]  o_sec_ff, o_sec_in;
   logic [5:0]  o_min_ff, o_min_in;
   logic [4:0]  o_hour_ff, o_hour_in;
   logic [4:0]  o_day_ff, o_day_in;
   logic [3:0]  o_month_ff, o_month_in;
   logic [11:0] o_year_ff, o_year_in;

   logic [31:0] recip;
   logic [63:0] prod;
   logic [31:0] quo;
   logic [5:0]  rem;
   logic        leap;
   logic [8:0]  year_len;
   logic [4:0]  mon_len;
   logic        out_free;
   logic        accept;
   logic        year_fit;
   logic        month_fit;

   es2d_sequencer u_seq (
      .clock  (clock),
      .reset  (reset),
      .status (status),
      .ctrl   (ctrl)
   );

   // Decode handshakes and calendar conditions
   assign req_ready = (ctrl.word.op == OP_WAIT);
   assign accept    = req_valid && req_ready;
   assign out_free  = !rsp_valid_ff || rsp_ready;
   assign leap      = ((mod4_ff == 2'd0) && (mod100_ff != 7'd0)) || (mod400_ff == 9'd0);
   assign year_len  = leap ? DAYS_LEAP : DAYS_COMMON;
   assign mon_len   = month_len(month_ff) + {4'd0, (month_ff == MONTH_FEB) && leap};
   assign year_fit  = (day_ff < {7'd0, year_len});
   assign month_fit = ((day_ff < {11'd0, mon_len}) || (month_ff == MONTH_DEC)) && out_free;

   assign status.accept    = accept;
   assign status.year_fit  = year_fit;
   assign status.month_fit = month_fit && (ctrl.word.op == OP_MONTH);

   // Quotient from the top bits of the reciprocal product
   assign recip = (ctrl.word.divisor == DIV_24) ? RECIP_24 : RECIP_60;
   assign prod  = 64'(q_ff) * 64'(recip);
   assign quo   = (ctrl.word.divisor == DIV_24) ? {4'd0, prod[63:36]} : {5'd0, prod[63:37]};
   // Remainder stays below 64, so six low bits of dividend minus quotient times divisor
   assign rem   = q_ff[5:0] - (quo_ff[5:0] * ctrl.word.divisor);

   // Datapath next state under the control word
   always_comb begin
      q_in      = q_ff;
      quo_in    = quo_ff;
      sec_in    = sec_ff;
      min_in    = min_ff;
      hour_in   = hour_ff;
      day_in    = day_ff;
      year_in   = year_ff;
      month_in  = month_ff;
      mod4_in   = mod4_ff;
      mod100_in = mod100_ff;
      mod400_in = mod400_ff;
      unique case (ctrl.word.op)
         OP_WAIT: begin
            // Load a new transaction
            if (accept) begin
               q_in      = req_epoch_seconds;
               year_in   = BASE_YEAR;
               month_in  = MONTH_JAN;
               mod4_in   = BASE_MOD4;
               mod100_in = BASE_MOD100;
               mod400_in = BASE_MOD400;
            end
         end
         OP_DIV: begin
            // Hold the quotient, then advance it and drop the remainder to its field
            if (ctrl.div_last) begin
               q_in = quo_ff;
               unique case (ctrl.word.dest)
                  DEST_SEC:  sec_in  = rem;
                  DEST_MIN:  min_in  = rem;
                  DEST_HOUR: begin
                     hour_in = rem[4:0];
                     day_in  = quo_ff[15:0];
                  end
                  default:   sec_in  = sec_ff;
               endcase
            end else begin
               quo_in = quo;
            end
         end
         OP_YEAR: begin
            // Remove one whole year and advance the year residues
            if (!year_fit) begin
               day_in    = day_ff - {7'd0, year_len};
               year_in   = year_ff + 12'd1;
               mod4_in   = mod4_ff + 2'd1;
               mod100_in = (mod100_ff == LAST_MOD100) ? 7'd0 : mod100_ff + 7'd1;
               mod400_in = (mod400_ff == LAST_MOD400) ? 9'd0 : mod400_ff + 9'd1;
            end
         end
         OP_MONTH: begin
            // Remove one whole month unless the day falls inside this one or it is December
            if ((day_ff >= {11'd0, mon_len}) && (month_ff != MONTH_DEC)) begin
               day_in   = day_ff - {11'd0, mon_len};
               month_in = month_ff + 4'd1;
            end
         end
         default: q_in = q_ff;
      endcase
   end

   // Output register: load on completion, release on the response handshake
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      o_sec_in     = o_sec_ff;
      o_min_in     = o_min_ff;
      o_hour_in    = o_hour_ff;
      o_day_in     = o_day_ff;
      o_month_in   = o_month_ff;
      o_year_in    = o_year_ff;
      priority if (status.month_fit) begin
         rsp_valid_in = 1'b1;
         o_sec_in     = sec_ff;
         o_min_in     = min_ff;
         o_hour_in    = hour_ff;
         o_day_in     = day_ff[4:0] + 5'd1;
         o_month_in   = month_ff;
         o_year_in    = year_ff;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      q_ff       <= q_in;
      quo_ff     <= quo_in;
      sec_ff     <= sec_in;
      min_ff     <= min_in;
      hour_ff    <= hour_in;
      day_ff     <= day_in;
      year_ff    <= year_in;
      month_ff   <= month_in;
      mod4_ff    <= mod4_in;
      mod100_ff  <= mod100_in;
      mod400_ff  <= mod400_in;
      o_sec_ff   <= o_sec_in;
      o_min_ff   <= o_min_in;
      o_hour_ff  <= o_hour_in;
      o_day_ff   <= o_day_in;
      o_month_ff <= o_month_in;
      o_year_ff  <= o_year_in;
   end

   assign rsp_valid            = rsp_valid_ff;
   assign rsp_second_of_minute = o_sec_ff;
   assign rsp_minute_of_hour   = o_min_ff;
   assign rsp_hour_of_day      = o_hour_ff;
   assign rsp_day_of_month     = o_day_ff;
   assign rsp_month_of_year    = o_month_ff;
   assign rsp_year             = o_year_ff;

endmodule
